>>> hw/rtl/u6cs_pkg.sv
`default_nettype none
package u6cs_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 2048;
  localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES);
  // The UDP length can exceed the 11-bit field when long frames are allowed.
  localparam int unsigned L4_W = (POS_W > 11) ? POS_W : 11;

  // Ones' complement accumulator kept folded to 17 bits.
  localparam int unsigned ACC_W = 17;
  localparam int unsigned FIN_W = 18;

  localparam logic [15:0] TPID_VLAN  = 16'h8100;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [L4_W-1:0] UDP_HDR_LEN = L4_W'(8);

  // Byte offsets for an untagged frame; a tag moves everything from the
  // IPv6 header onward by TAG_LEN bytes.
  localparam logic [POS_W-1:0] TAG_LEN          = POS_W'(4);
  localparam logic [POS_W-1:0] POS_ETYPE        = POS_W'(13);
  localparam logic [POS_W-1:0] POS_ETYPE_TAGGED = POS_W'(17);
  localparam logic [POS_W-1:0] POS_NEXT_HDR     = POS_W'(20);
  localparam logic [POS_W-1:0] POS_ADDR_START   = POS_W'(22);
  localparam logic [POS_W-1:0] POS_DPORT_LO     = POS_W'(57);
  localparam logic [POS_W-1:0] POS_CSUM_HI      = POS_W'(60);
  localparam logic [POS_W-1:0] POS_CSUM_LO      = POS_W'(61);
  localparam logic [POS_W-1:0] POS_LAST         = POS_W'(MAX_FRAME_BYTES - 1);
  localparam logic [POS_W:0]   HDR_LEN          = (POS_W + 1)'(54);

  localparam logic [6:0] CSUM_OFF_BASE = 7'd60;
  localparam logic [6:0] CSUM_OFF_TAG  = 7'd4;

  // Configuration register indexes (paddr[3:2]).
  localparam logic [1:0] REG_MATCH_PORT = 2'd0;
  localparam logic [1:0] REG_MIN_L4     = 2'd1;
  localparam logic [1:0] REG_MAX_L4     = 2'd2;

  localparam logic [15:0] MATCH_PORT_RST = 16'd4739;
  localparam logic [10:0] MIN_L4_RST     = 11'd16;
  localparam logic [10:0] MAX_L4_RST     = 11'd1460;

  // Depth of the queue between front and back.
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } frame_t;

  typedef struct packed {
    logic        qualified;
    logic [15:0] udp_checksum;
    logic [6:0]  checksum_offset;
    logic [10:0] l4_length;
  } result_t;

  typedef struct packed {
    logic [15:0] match_port;
    logic [10:0] min_l4_length;
    logic [10:0] max_l4_length;
  } cfg_t;

  // One classified byte handed from front to back.
  typedef struct packed {
    logic [15:0]     contrib;
    logic            last;
    logic            headers_ok;
    logic            tag_seen;
    logic [L4_W-1:0] l4;
  } item_t;

endpackage
`default_nettype wire

>>> hw/rtl/u6cs_front.sv
`default_nettype none
module u6cs_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire u6cs_pkg::frame_t frame_i,
  input  wire logic [15:0]     match_port_i,
  output u6cs_pkg::item_t      item_o
);
  import u6cs_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  logic             tag_q, tag_d;
  logic [15:0]      hw_q, hw_d;
  logic             ok_q, ok_d;

  logic [15:0]      hw_new;
  logic [POS_W-1:0] shift;
  logic             ok_hdr;
  logic             add_en;
  logic [POS_W:0]   len;
  logic [POS_W:0]   hdr;
  logic [POS_W:0]   l4_full;

  always_comb begin
    hw_new = {hw_q[7:0], frame_i.frame_byte};
    shift  = tag_q ? TAG_LEN : '0;

    tag_d  = tag_q;
    ok_hdr = ok_q;
    if (pos_q == POS_ETYPE) begin
      if (hw_new == TPID_VLAN) begin
        tag_d  = 1'b1;
        ok_hdr = 1'b0;
      end else begin
        ok_hdr = (hw_new == ETYPE_IPV6);
      end
    end else if (pos_q == POS_ETYPE_TAGGED && tag_q) begin
      ok_hdr = (hw_new == ETYPE_IPV6);
    end
    if (pos_q == POS_NEXT_HDR + shift && frame_i.frame_byte != PROTO_UDP) begin
      ok_hdr = 1'b0;
    end
    if (pos_q == POS_DPORT_LO + shift && hw_new != match_port_i) begin
      ok_hdr = 1'b0;
    end

    // Addresses, UDP header and payload; the checksum field counts as zero.
    add_en = (pos_q >= POS_ADDR_START + shift) && (pos_q != POS_CSUM_HI + shift) &&
             (pos_q != POS_CSUM_LO + shift);
    if (!add_en) begin
      item_o.contrib = '0;
    end else if (pos_q[0]) begin
      item_o.contrib = {8'd0, frame_i.frame_byte};
    end else begin
      item_o.contrib = {frame_i.frame_byte, 8'd0};
    end

    len     = {1'b0, pos_q} + (POS_W + 1)'(1);
    hdr     = HDR_LEN + {1'b0, shift};
    l4_full = (len >= hdr) ? (len - hdr) : '0;

    item_o.last       = frame_i.frame_end;
    item_o.headers_ok = ok_hdr && (pos_q > POS_DPORT_LO + shift);
    item_o.tag_seen   = tag_q;
    item_o.l4         = L4_W'(l4_full);

    pos_d = pos_q;
    hw_d  = hw_q;
    ok_d  = ok_q;
    if (accept_i) begin
      if (frame_i.frame_end) begin
        pos_d = '0;
        tag_d = 1'b0;
        hw_d  = '0;
        ok_d  = 1'b0;
      end else begin
        hw_d = hw_new;
        ok_d = ok_hdr;
        if (pos_q >= POS_LAST) begin
          // Oversize frame: the position sticks and the frame is rejected.
          pos_d = POS_LAST;
          ok_d  = 1'b0;
        end else begin
          pos_d = pos_q + POS_W'(1);
        end
      end
    end else begin
      tag_d = tag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      tag_q <= 1'b0;
      hw_q  <= '0;
      ok_q  <= 1'b0;
    end else begin
      pos_q <= pos_d;
      tag_q <= tag_d;
      hw_q  <= hw_d;
      ok_q  <= ok_d;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/u6cs_queue.sv
`default_nettype none
module u6cs_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire u6cs_pkg::item_t item_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output u6cs_pkg::item_t     item_o
);
  import u6cs_pkg::*;

  item_t              mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_q, wr_d;
  logic [Q_PTR_W-1:0] rd_q, rd_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic               do_push;
  logic               do_pop;

  assign full_o  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + Q_PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + Q_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/u6cs_back.sv
`default_nettype none
module u6cs_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire u6cs_pkg::item_t item_i,
  output logic                 pop_o,
  input  wire u6cs_pkg::cfg_t  cfg_i,
  output logic                 empty_o,
  input  wire logic            pop_i,
  output u6cs_pkg::result_t    result_o
);
  import u6cs_pkg::*;

  logic [ACC_W-1:0] acc_q, acc_d;
  logic [ACC_W:0]   acc_sum;
  logic [ACC_W-1:0] acc_fold;

  // Finishing stage: one frame's folded sum waiting for the pseudo-header.
  logic             fin_valid_q, fin_valid_d;
  logic [ACC_W-1:0] fin_sum_q;
  logic             fin_ok_q;
  logic             fin_tag_q;
  logic [L4_W-1:0]  fin_l4_q;

  // Two-entry result queue.
  result_t          res_q [2];
  logic             res_wr_q, res_rd_q;
  logic [1:0]       res_cnt_q, res_cnt_d;
  logic             res_full;
  logic             res_push;
  logic             res_pop;

  logic             len_ok;
  logic             qual;
  logic [FIN_W-1:0] ph_sum;
  logic [16:0]      fold1;
  logic [15:0]      fold2;
  logic [15:0]      csum;
  result_t          res_new;

  assign res_full = (res_cnt_q == 2'd2);
  assign res_push = fin_valid_q && !res_full;
  assign res_pop  = pop_i && (res_cnt_q != 2'd0);
  assign empty_o  = (res_cnt_q == 2'd0);
  assign result_o = res_q[res_rd_q];

  // A frame's last byte needs the finishing stage; other bytes only add.
  assign pop_o = valid_i && (!item_i.last || !fin_valid_q || res_push);

  always_comb begin
    acc_sum  = {1'b0, acc_q} + {2'd0, item_i.contrib};
    acc_fold = {1'b0, acc_sum[15:0]} + ACC_W'(acc_sum[ACC_W:16]);
    acc_d    = acc_q;
    if (pop_o) begin
      acc_d = item_i.last ? '0 : acc_fold;
    end
  end

  always_comb begin
    len_ok = (fin_l4_q >= UDP_HDR_LEN) &&
             (fin_l4_q >= L4_W'(cfg_i.min_l4_length)) &&
             (fin_l4_q <= L4_W'(cfg_i.max_l4_length));
    qual   = fin_ok_q && len_ok;
    ph_sum = FIN_W'(fin_sum_q) + FIN_W'(fin_l4_q) + FIN_W'(PROTO_UDP);
    fold1  = {1'b0, ph_sum[15:0]} + 17'(ph_sum[FIN_W-1:16]);
    fold2  = fold1[15:0] + 16'(fold1[16]);
    csum   = ~fold2;
    if (csum == 16'd0) begin
      csum = 16'hFFFF;
    end
    res_new.qualified       = qual;
    res_new.udp_checksum    = qual ? csum : 16'd0;
    res_new.checksum_offset = CSUM_OFF_BASE + (fin_tag_q ? CSUM_OFF_TAG : 7'd0);
    res_new.l4_length       = fin_l4_q[10:0];

    fin_valid_d = fin_valid_q;
    if (pop_o && item_i.last) begin
      fin_valid_d = 1'b1;
    end else if (res_push) begin
      fin_valid_d = 1'b0;
    end

    res_cnt_d = res_cnt_q;
    if (res_push && !res_pop) begin
      res_cnt_d = res_cnt_q + 2'd1;
    end else if (res_pop && !res_push) begin
      res_cnt_d = res_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && item_i.last) begin
      fin_sum_q <= acc_fold;
      fin_ok_q  <= item_i.headers_ok;
      fin_tag_q <= item_i.tag_seen;
      fin_l4_q  <= item_i.l4;
    end
    if (res_push) begin
      res_q[res_wr_q] <= res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      fin_valid_q <= 1'b0;
      res_wr_q    <= 1'b0;
      res_rd_q    <= 1'b0;
      res_cnt_q   <= '0;
    end else begin
      acc_q       <= acc_d;
      fin_valid_q <= fin_valid_d;
      res_cnt_q   <= res_cnt_d;
      if (res_push) begin
        res_wr_q <= ~res_wr_q;
      end
      if (res_pop) begin
        res_rd_q <= ~res_rd_q;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/udp_ipv6_checksum_recompute_unit.sv
// Accepts one frame byte per cycle; full rises only when the byte queue backs up.
// After the last byte of its frame is accepted, a result passes through the byte
// queue, accumulator with finishing register, then the result queue. Results
// drain at one per cycle; the accumulator takes one byte per cycle unless held.
// Reset (rst_ni low, asynchronous) empties both queues, clears the frame state
// and restores the configuration registers to their default values.
`default_nettype none
module udp_ipv6_checksum_recompute_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire u6cs_pkg::frame_t  in_frame_i,
  output logic                   empty,
  input  wire logic              pop,
  output u6cs_pkg::result_t      result_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import u6cs_pkg::*;

  cfg_t  cfg_q, cfg_d;
  logic  accept;
  logic  wr_en;
  item_t front_item;
  item_t q_item;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign full   = q_full;
  assign accept = push && !q_full;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[3:2])
        REG_MATCH_PORT: cfg_d.match_port    = pwdata[15:0];
        REG_MIN_L4:     cfg_d.min_l4_length = pwdata[10:0];
        REG_MAX_L4:     cfg_d.max_l4_length = pwdata[10:0];
        default:        cfg_d = cfg_q;
      endcase
    end
    case (paddr[3:2])
      REG_MATCH_PORT: prdata = {16'd0, cfg_q.match_port};
      REG_MIN_L4:     prdata = {21'd0, cfg_q.min_l4_length};
      REG_MAX_L4:     prdata = {21'd0, cfg_q.max_l4_length};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.match_port    <= MATCH_PORT_RST;
      cfg_q.min_l4_length <= MIN_L4_RST;
      cfg_q.max_l4_length <= MAX_L4_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  u6cs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .frame_i      (in_frame_i),
    .match_port_i (cfg_q.match_port),
    .item_o       (front_item)
  );

  u6cs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  u6cs_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (q_valid),
    .item_i   (q_item),
    .pop_o    (q_pop),
    .cfg_i    (cfg_q),
    .empty_o  (empty),
    .pop_i    (pop),
    .result_o (result_o)
  );

endmodule
`default_nettype wire
